// ----- rtl/core/three_channel_moving_average_scaler_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the moving-average scaler
// Checks compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef THREE_CHANNEL_MOVING_AVERAGE_SCALER_MACROS_SVH
`define THREE_CHANNEL_MOVING_AVERAGE_SCALER_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked outside reset, sampled on clk
`define TCMAS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tcmas assertion failed");

// property that must also hold while reset is applied
`define TCMAS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tcmas assertion failed");

`else

`define TCMAS_ASSERT(lbl, prop)

`define TCMAS_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ----- rtl/core/tcmas_pkg.sv -----
// ----------------------------------------------------------------------------
// tcmas_pkg
// Shared widths, constants, register indexes and types of the scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package tcmas_pkg;

    localparam int WINDOW_DEPTH_DEF = 5;
    localparam int SLOT_COUNT       = 5;
    localparam int NUM_QTY          = 3;

    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 10;
    localparam int AVG_W    = 10;
    localparam int SCALE_W  = 16;
    localparam int CHAN_W   = 4;
    localparam int SLOT_W   = 3;
    localparam int QID_W    = 2;
    localparam int OUT_W    = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int AVG_MAX       = 1020;
    localparam int SCALE_DIVISOR = 10;

    // scale * average, and the divide-by-ten reciprocal
    localparam int PROD_W         = SCALE_W + AVG_W;
    localparam int DIV10_SHIFT    = PROD_W + 4;
    localparam longint DIV10_MULT =
        ((longint'(1) << DIV10_SHIFT) + SCALE_DIVISOR - 1) / SCALE_DIVISOR;
    localparam int DIV10_MULT_W   = PROD_W + 1;
    localparam int QFULL_W        = PROD_W + DIV10_MULT_W;
    localparam int QUOT_W         = QFULL_W - DIV10_SHIFT;

    localparam logic [OUT_W-1:0]   SAT_MAX     = '1;
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(10);

    localparam logic [CHAN_W-1:0] INJ_CHAN_RESET = CHAN_W'(0);
    localparam logic [CHAN_W-1:0] NDL_CHAN_RESET = CHAN_W'(1);
    localparam logic [CHAN_W-1:0] BAT_CHAN_RESET = CHAN_W'(2);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INJ_SCALE = 3'd0,
        REG_NDL_SCALE = 3'd1,
        REG_BAT_SCALE = 3'd2,
        REG_INJ_CHAN  = 3'd3,
        REG_NDL_CHAN  = 3'd4,
        REG_BAT_CHAN  = 3'd5
    } reg_index_t;

    typedef enum logic [QID_W-1:0] {
        QTY_INJ = 2'd0,
        QTY_NDL = 2'd1,
        QTY_BAT = 2'd2
    } qty_t;

    // per-item bookkeeping carried alongside the arithmetic
    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic              quantity_valid;
        logic [QID_W-1:0]  quantity_id;
        logic [CHAN_W-1:0] next_channel;
    } meta_t;

endpackage

`default_nettype wire

// ----- rtl/core/three_channel_moving_average_scaler.sv -----
// ----------------------------------------------------------------------------
// three_channel_moving_average_scaler
// Three-quantity moving-average filter with scaling and channel sequencing.
// ----------------------------------------------------------------------------
// Usage:
//   One input transfer per converter sample period carries the high result
//   byte. Slots 0..2 update injection current, needle current and battery
//   voltage windows; the remaining slots are idle and return zeros. Every
//   input transfer produces exactly one result transfer, in order.
//   Configuration writes (scales, converter channels) go through the cfg
//   channel, which is always ready; write them only while the block is idle.
//   out_valid rises once the input transfer has passed through four
//   registers (window sum, mean, scale multiply, divide by ten).
//   Throughput: one item per cycle while out_ready is high, set by the
//   four-stage pipeline with at most one multiply per stage.
//   Receiver stall: the result register holds; earlier stages keep filling,
//   so up to four items are held before in_ready drops.
//   Reset: windows and slot counter clear, scales return to 10, channels to
//   0, 1 and 2; the pipeline empties.
// ----------------------------------------------------------------------------
`default_nettype none

module three_channel_moving_average_scaler
    import tcmas_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [BYTE_W-1:0]      adc_high_byte,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [SLOT_W-1:0]           slot_index,
    output logic                        quantity_valid,
    output logic [QID_W-1:0]            quantity_id,
    output logic [AVG_W-1:0]            window_average,
    output logic [OUT_W-1:0]            scaled_value,
    output logic                        scale_saturated,
    output logic [CHAN_W-1:0]           next_channel
);

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);

    logic [NUM_QTY-1:0][SCALE_W-1:0] scale_reg;
    logic [NUM_QTY-1:0][CHAN_W-1:0]  chan_reg;

    logic             sum_valid;
    logic             sum_ready;
    logic [SUM_W-1:0] sum;
    meta_t            sum_meta;
    meta_t            out_meta;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg[QTY_INJ] <= SCALE_RESET;
            scale_reg[QTY_NDL] <= SCALE_RESET;
            scale_reg[QTY_BAT] <= SCALE_RESET;
            chan_reg[QTY_INJ]  <= INJ_CHAN_RESET;
            chan_reg[QTY_NDL]  <= NDL_CHAN_RESET;
            chan_reg[QTY_BAT]  <= BAT_CHAN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_INJ_SCALE: scale_reg[QTY_INJ] <= cfg_data;
                REG_NDL_SCALE: scale_reg[QTY_NDL] <= cfg_data;
                REG_BAT_SCALE: scale_reg[QTY_BAT] <= cfg_data;
                REG_INJ_CHAN:  chan_reg[QTY_INJ]  <= cfg_data[CHAN_W-1:0];
                REG_NDL_CHAN:  chan_reg[QTY_NDL]  <= cfg_data[CHAN_W-1:0];
                REG_BAT_CHAN:  chan_reg[QTY_BAT]  <= cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    tcmas_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .adc_high_byte (adc_high_byte),
        .channels      (chan_reg),
        .sum_valid     (sum_valid),
        .sum_ready     (sum_ready),
        .sum           (sum),
        .sum_meta      (sum_meta)
    );

    tcmas_scale #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .sum_valid     (sum_valid),
        .sum_ready     (sum_ready),
        .sum           (sum),
        .sum_meta      (sum_meta),
        .scales        (scale_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_meta      (out_meta),
        .out_average   (window_average),
        .out_scaled    (scaled_value),
        .out_saturated (scale_saturated)
    );

    assign slot_index     = out_meta.slot_index;
    assign quantity_valid = out_meta.quantity_valid;
    assign quantity_id    = out_meta.quantity_id;
    assign next_channel   = out_meta.next_channel;

endmodule

`default_nettype wire

// ----- rtl/core/tcmas_window.sv -----
// ----------------------------------------------------------------------------
// tcmas_window
// Slot counter, per-quantity sample windows and registered window sum.
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_channel_moving_average_scaler_macros.svh"

module tcmas_window
    import tcmas_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [BYTE_W-1:0]              adc_high_byte,
    input  wire logic [NUM_QTY-1:0][CHAN_W-1:0] channels,
    output logic                                sum_valid,
    input  wire logic                           sum_ready,
    output logic [SUM_W-1:0]                    sum,
    output meta_t                               sum_meta
);

    localparam int TAPS = WINDOW_DEPTH - 1;

    logic [SAMPLE_W-1:0] win_reg [NUM_QTY][TAPS];
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic                sum_valid_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    meta_t               meta_reg;
    meta_t               meta_next;

    logic [SAMPLE_W-1:0] sample;
    logic [SUM_W-1:0]    row_sum [NUM_QTY];
    logic                load;
    logic                accept;

    assign load     = !sum_valid_reg || sum_ready;
    assign in_ready = load;
    assign accept   = in_valid && in_ready;
    assign sample   = {adc_high_byte, 2'b00};

    always_comb
    begin
        slot_next = (slot_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0 : slot_reg + 1'b1;

        meta_next.slot_index     = slot_reg;
        meta_next.quantity_valid = (slot_reg < SLOT_W'(NUM_QTY));
        meta_next.quantity_id    = meta_next.quantity_valid ? QID_W'(slot_reg) : '0;
        // idle slots hand over to slot 0, the injection channel
        case (slot_next)
            SLOT_W'(QTY_NDL): meta_next.next_channel = channels[QTY_NDL];
            SLOT_W'(QTY_BAT): meta_next.next_channel = channels[QTY_BAT];
            default:          meta_next.next_channel = channels[QTY_INJ];
        endcase
    end

    // sum over the window after the new sample has gone in
    always_comb
    begin
        for (int q = 0; q < NUM_QTY; q++)
        begin
            row_sum[q] = SUM_W'(sample);
            for (int i = 0; i < TAPS; i++)
            begin
                row_sum[q] = row_sum[q] + SUM_W'(win_reg[q][i]);
            end
        end

        case (meta_next.quantity_id)
            QTY_NDL: sum_next = row_sum[1];
            QTY_BAT: sum_next = row_sum[2];
            default: sum_next = row_sum[0];
        endcase
        if (!meta_next.quantity_valid)
        begin
            sum_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < NUM_QTY; q++)
            begin
                for (int i = 0; i < TAPS; i++)
                begin
                    win_reg[q][i] <= '0;
                end
            end
        end
        else if (accept && meta_next.quantity_valid)
        begin
            for (int q = 0; q < NUM_QTY; q++)
            begin
                if (meta_next.quantity_id == QID_W'(q))
                begin
                    win_reg[q][0] <= sample;
                    for (int i = 1; i < TAPS; i++)
                    begin
                        win_reg[q][i] <= win_reg[q][i-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                slot_reg <= slot_next;
            end
            if (load)
            begin
                sum_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_reg  <= sum_next;
            meta_reg <= meta_next;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;
    assign sum_meta  = meta_reg;

    `TCMAS_ASSERT(a_slot_range, slot_reg < SLOT_W'(SLOT_COUNT))
    `TCMAS_ASSERT(a_accept_fills, accept |=> sum_valid_reg)
    `TCMAS_ASSERT(a_slot_step, accept |=> slot_reg == $past(slot_next))
    `TCMAS_ASSERT(a_idle_zero, sum_valid_reg && !meta_reg.quantity_valid |-> sum_reg == '0)

endmodule

`default_nettype wire

// ----- rtl/core/tcmas_scale.sv -----
// ----------------------------------------------------------------------------
// tcmas_scale
// Window mean, scale multiply, divide by ten with saturation, result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_channel_moving_average_scaler_macros.svh"

module tcmas_scale
    import tcmas_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            sum_valid,
    output logic                                 sum_ready,
    input  wire logic [SUM_W-1:0]                sum,
    input  wire meta_t                           sum_meta,
    input  wire logic [NUM_QTY-1:0][SCALE_W-1:0] scales,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output meta_t                                out_meta,
    output logic [AVG_W-1:0]                     out_average,
    output logic [OUT_W-1:0]                     out_scaled,
    output logic                                 out_saturated
);

    // mean by reciprocal: exact for every sum below 2**SUM_W
    localparam int DEPTH_LOG  = $clog2(WINDOW_DEPTH);
    localparam int DIV_SHIFT  = SUM_W + DEPTH_LOG;
    localparam int DIV_MULT   = ((2 ** DIV_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
    localparam int MULT_W     = SUM_W + 2;
    localparam int AVG_PROD_W = SUM_W + MULT_W;

    logic                avg_valid_reg;
    logic [AVG_W-1:0]    avg_reg;
    logic [AVG_W-1:0]    avg_next;
    meta_t               avg_meta_reg;

    logic                prod_valid_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    logic [AVG_W-1:0]    prod_avg_reg;
    meta_t               prod_meta_reg;

    logic                out_valid_reg;
    meta_t               out_meta_reg;
    logic [AVG_W-1:0]    out_avg_reg;
    logic [OUT_W-1:0]    out_scaled_reg;
    logic [OUT_W-1:0]    out_scaled_next;
    logic                out_sat_reg;
    logic                out_sat_next;

    logic [AVG_PROD_W-1:0] avg_full;
    logic [SCALE_W-1:0]    scale_sel;
    logic [QFULL_W-1:0]    quot_full;
    logic [QUOT_W-1:0]     quot;

    logic load_avg;
    logic load_prod;
    logic load_out;

    assign load_out  = !out_valid_reg || out_ready;
    assign load_prod = !prod_valid_reg || load_out;
    assign load_avg  = !avg_valid_reg || load_prod;
    assign sum_ready = load_avg;

    assign avg_full = AVG_PROD_W'(sum) * AVG_PROD_W'(DIV_MULT);
    assign avg_next = avg_full[DIV_SHIFT +: AVG_W];

    always_comb
    begin
        case (avg_meta_reg.quantity_id)
            QTY_INJ: scale_sel = scales[QTY_INJ];
            QTY_NDL: scale_sel = scales[QTY_NDL];
            default: scale_sel = scales[QTY_BAT];
        endcase
    end

    assign prod_next = PROD_W'(scale_sel) * PROD_W'(avg_reg);

    assign quot_full = QFULL_W'(prod_reg) * QFULL_W'(DIV10_MULT);
    assign quot      = quot_full[DIV10_SHIFT +: QUOT_W];

    always_comb
    begin
        out_sat_next    = (quot > QUOT_W'(SAT_MAX));
        out_scaled_next = out_sat_next ? SAT_MAX : quot[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load_avg)
            begin
                avg_valid_reg <= sum_valid;
            end
            if (load_prod)
            begin
                prod_valid_reg <= avg_valid_reg;
            end
            if (load_out)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_avg && sum_valid)
        begin
            avg_reg      <= avg_next;
            avg_meta_reg <= sum_meta;
        end
        if (load_prod && avg_valid_reg)
        begin
            prod_reg      <= prod_next;
            prod_avg_reg  <= avg_reg;
            prod_meta_reg <= avg_meta_reg;
        end
        if (load_out && prod_valid_reg)
        begin
            out_meta_reg   <= prod_meta_reg;
            out_avg_reg    <= prod_avg_reg;
            out_scaled_reg <= out_scaled_next;
            out_sat_reg    <= out_sat_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_meta      = out_meta_reg;
    assign out_average   = out_avg_reg;
    assign out_scaled    = out_scaled_reg;
    assign out_saturated = out_sat_reg;

    `TCMAS_ASSERT(a_avg_bound, avg_valid_reg |-> avg_reg <= AVG_W'(AVG_MAX))
    `TCMAS_ASSERT(a_sat_clip, out_valid_reg && out_sat_reg |-> out_scaled_reg == SAT_MAX)
    `TCMAS_ASSERT(a_idle_result, out_valid_reg && !out_meta_reg.quantity_valid |-> out_scaled_reg == '0 && !out_sat_reg && out_avg_reg == '0)
    `TCMAS_ASSERT(a_stage_move, prod_valid_reg && load_out |=> out_valid_reg)

endmodule

`default_nettype wire

// ----- tb/tcmas_result_checker.sv -----
// ----------------------------------------------------------------------------
// tcmas_result_checker
// Watches the config, sample and result channels of the moving-average
// scaler. Keeps its own copy of the windows, slot count and registers, works
// out the result of every accepted sample, and compares each result transfer
// in order against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tcmas_result_checker
    import tcmas_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    input  wire logic                   in_ready,
    input  wire logic [BYTE_W-1:0]      adc_high_byte,
    input  wire logic                   out_valid,
    input  wire logic                   out_ready,
    input  wire logic [SLOT_W-1:0]      slot_index,
    input  wire logic                   quantity_valid,
    input  wire logic [QID_W-1:0]       quantity_id,
    input  wire logic [AVG_W-1:0]       window_average,
    input  wire logic [OUT_W-1:0]       scaled_value,
    input  wire logic                   scale_saturated,
    input  wire logic [CHAN_W-1:0]      next_channel,
    output int                          error_count,
    output int                          results_owed
);

    localparam int DEPTH        = WINDOW_DEPTH_DEF;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic              quantity_valid;
        logic [QID_W-1:0]  quantity_id;
        logic [AVG_W-1:0]  window_average;
        logic [OUT_W-1:0]  scaled_value;
        logic              scale_saturated;
        logic [CHAN_W-1:0] next_channel;
    } slot_result_t;

    logic [SAMPLE_W-1:0] windows   [NUM_QTY][DEPTH];
    logic [SLOT_W-1:0]   slot_now;
    logic [SCALE_W-1:0]  scale_reg [NUM_QTY];
    logic [CHAN_W-1:0]   chan_reg  [NUM_QTY];
    slot_result_t        awaited_results[$];
    int                  mismatch_total;

    // shifts one sample into its quantity's window and returns the result
    function automatic slot_result_t filter_sample(input logic [BYTE_W-1:0] raw);
        slot_result_t r;
        int unsigned  slot;
        int unsigned  nxt;
        int unsigned  sum;
        int unsigned  prod;
        qty_t         q;
        r    = '0;
        slot = slot_now;
        if (slot >= SLOT_COUNT)
            slot = 0;
        if (slot < NUM_QTY)
        begin
            q = qty_t'(slot);
            for (int i = DEPTH - 1; i > 0; i--)
                windows[q][i] = windows[q][i-1];
            windows[q][0] = SAMPLE_W'(raw) << 2;
            sum = 0;
            for (int i = 0; i < DEPTH; i++)
                sum += windows[q][i];
            r.window_average = AVG_W'(sum / DEPTH);
            prod = (32'(scale_reg[q]) * 32'(r.window_average)) / SCALE_DIVISOR;
            if (prod > SAT_MAX)
            begin
                r.scaled_value    = SAT_MAX;
                r.scale_saturated = 1'b1;
            end
            else
            begin
                r.scaled_value = OUT_W'(prod);
            end
            r.quantity_valid = 1'b1;
            r.quantity_id    = q;
        end
        nxt = slot + 1;
        if (nxt >= SLOT_COUNT)
            nxt = 0;
        slot_now       = SLOT_W'(nxt);
        r.slot_index   = SLOT_W'(slot);
        // idle slots hand over to slot 0, the next one that samples
        r.next_channel = (nxt < NUM_QTY) ? chan_reg[nxt] : chan_reg[QTY_INJ];
        return r;
    endfunction

    always @(posedge clk)
    begin
        slot_result_t got;
        slot_result_t want;
        if (!rst_n)
        begin
            for (int q = 0; q < NUM_QTY; q++)
            begin
                for (int i = 0; i < DEPTH; i++)
                    windows[q][i] = '0;
                scale_reg[q] = SCALE_RESET;
            end
            chan_reg[QTY_INJ] = INJ_CHAN_RESET;
            chan_reg[QTY_NDL] = NDL_CHAN_RESET;
            chan_reg[QTY_BAT] = BAT_CHAN_RESET;
            slot_now          = '0;
            mismatch_total    = 0;
            awaited_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_INJ_SCALE: scale_reg[QTY_INJ] = cfg_data[SCALE_W-1:0];
                    REG_NDL_SCALE: scale_reg[QTY_NDL] = cfg_data[SCALE_W-1:0];
                    REG_BAT_SCALE: scale_reg[QTY_BAT] = cfg_data[SCALE_W-1:0];
                    REG_INJ_CHAN:  chan_reg[QTY_INJ]  = cfg_data[CHAN_W-1:0];
                    REG_NDL_CHAN:  chan_reg[QTY_NDL]  = cfg_data[CHAN_W-1:0];
                    REG_BAT_CHAN:  chan_reg[QTY_BAT]  = cfg_data[CHAN_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got = {slot_index, quantity_valid, quantity_id, window_average,
                       scaled_value, scale_saturated, next_channel};
                if (awaited_results.size() == 0)
                begin
                    mismatch_total++;
                    if (mismatch_total <= REPORT_LIMIT)
                        $display("%0t: result transfer with none outstanding: %p",
                                 $time, got);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got !== want)
                    begin
                        mismatch_total++;
                        if (mismatch_total <= REPORT_LIMIT)
                            $display({"%0t: mismatch slot %0d/%0d valid %0d/%0d ",
                                      "qty %0d/%0d avg %0d/%0d scaled %0d/%0d ",
                                      "sat %0d/%0d chan %0d/%0d (exp/got)"},
                                     $time,
                                     want.slot_index, got.slot_index,
                                     want.quantity_valid, got.quantity_valid,
                                     want.quantity_id, got.quantity_id,
                                     want.window_average, got.window_average,
                                     want.scaled_value, got.scaled_value,
                                     want.scale_saturated, got.scale_saturated,
                                     want.next_channel, got.next_channel);
                    end
                end
            end
            if (in_valid && in_ready)
                awaited_results.push_back(filter_sample(adc_high_byte));
        end
        error_count  <= mismatch_total;
        results_owed <= awaited_results.size();
    end

endmodule

`default_nettype wire

// ----- tb/tb_three_channel_moving_average_scaler.sv -----
// ----------------------------------------------------------------------------
// tb_three_channel_moving_average_scaler
// Drives samples and register writes into the scaler with random pacing on
// both the sample and result channels. A short directed run covers the byte
// extremes, idle slots, wrap and saturation; random phases with fresh
// register settings follow. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_three_channel_moving_average_scaler
    import tcmas_pkg::*;
;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 300;
    localparam int DRAIN_CYCLES  = 8;

    // indexes beyond the register map; writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam logic [BYTE_W-1:0]     BYTE_MAX = '1;
    localparam logic [CFG_DATA_W-1:0] DATA_MAX = '1;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   in_valid      = 1'b0;
    logic [BYTE_W-1:0]      adc_high_byte = '0;
    logic                   out_ready     = 1'b0;

    wire logic              cfg_ready;
    wire logic              in_ready;
    wire logic              out_valid;
    wire logic [SLOT_W-1:0] slot_index;
    wire logic              quantity_valid;
    wire logic [QID_W-1:0]  quantity_id;
    wire logic [AVG_W-1:0]  window_average;
    wire logic [OUT_W-1:0]  scaled_value;
    wire logic              scale_saturated;
    wire logic [CHAN_W-1:0] next_channel;

    int error_count;
    int results_owed;
    int gap_odds    = 4;   // chance in 16 of a sender pause after a transfer
    int stall_odds  = 4;   // chance in 16 of a receiver stall per cycle
    int cycle_count = 0;

    three_channel_moving_average_scaler dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .adc_high_byte   (adc_high_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .slot_index      (slot_index),
        .quantity_valid  (quantity_valid),
        .quantity_id     (quantity_id),
        .window_average  (window_average),
        .scaled_value    (scaled_value),
        .scale_saturated (scale_saturated),
        .next_channel    (next_channel)
    );

    tcmas_result_checker result_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .adc_high_byte   (adc_high_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .slot_index      (slot_index),
        .quantity_valid  (quantity_valid),
        .quantity_id     (quantity_id),
        .window_average  (window_average),
        .scaled_value    (scaled_value),
        .scale_saturated (scale_saturated),
        .next_channel    (next_channel),
        .error_count     (error_count),
        .results_owed    (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side back-pressure, in bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && stall_odds > 0 && $urandom_range(0, 15) < stall_odds)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // valid stays high into the next call unless a pause is taken
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        in_valid      <= 1'b1;
        adc_high_byte <= b;
        do @(posedge clk); while (!in_ready);
        if (gap_odds > 0 && $urandom_range(0, 15) < gap_odds)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_setting(input logic [CFG_DATA_W-1:0] inj_s,
                                input logic [CFG_DATA_W-1:0] ndl_s,
                                input logic [CFG_DATA_W-1:0] bat_s,
                                input logic [CFG_DATA_W-1:0] inj_c,
                                input logic [CFG_DATA_W-1:0] ndl_c,
                                input logic [CFG_DATA_W-1:0] bat_c,
                                input bit                    with_spare);
        write_reg(REG_INJ_SCALE, inj_s);
        write_reg(REG_NDL_SCALE, ndl_s);
        write_reg(REG_BAT_SCALE, bat_s);
        write_reg(REG_INJ_CHAN, inj_c);
        write_reg(REG_NDL_CHAN, ndl_c);
        write_reg(REG_BAT_CHAN, bat_c);
        if (with_spare)
        begin
            write_reg(REG_SPARE_6, CFG_DATA_W'($urandom));
            write_reg(REG_SPARE_7, CFG_DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_scale();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return DATA_MAX;
            2:       return CFG_DATA_W'($urandom_range(0, 20));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // random-length runs, some long enough to fill all windows with one value, plus noise
    task automatic run_phase(input int count);
        int               sent;
        int               run_len;
        int               mode;
        logic [BYTE_W-1:0] b;
        sent = 0;
        while (sent < count)
        begin
            run_len = $urandom_range(1, 30);
            mode    = $urandom_range(0, 3);
            b       = BYTE_W'($urandom);
            repeat (run_len)
            begin
                if (sent < count)
                begin
                    case (mode)
                        0:       b = BYTE_W'($urandom);
                        1:       ;
                        2:       b = $urandom_range(0, 1) ? BYTE_MAX : '0;
                        default: b = b ^ (BYTE_W'(1) << $urandom_range(0, BYTE_W - 1));
                    endcase
                    send_byte(b);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        int p;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: two trips round all five slots
        send_byte('0);
        repeat (9) send_byte(BYTE_MAX);
        wait_drained();

        // injection saturates, needle scaled to zero, battery just under the
        // clip; needle channel data has upper bits that must be dropped
        load_setting(DATA_MAX, '0, 16'd641, 16'h000F, 16'hFFF7, 16'h0009, 1'b1);
        repeat (10) send_byte(BYTE_MAX);
        send_byte(8'd1);
        send_byte('0);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(BYTE_MAX);

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            if (p == 1)
                load_setting('0, '0, '0, '0, '0, '0, 1'b0);
            else if (p == RANDOM_PHASES - 2)
                load_setting(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX,
                             DATA_MAX, 1'b1);
            else
                load_setting(pick_scale(), pick_scale(), pick_scale(),
                             CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                             CFG_DATA_W'($urandom), 1'($urandom_range(0, 1)));
            if (p == 2 || p == RANDOM_PHASES - 1)
            begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            else
            begin
                gap_odds   = $urandom_range(1, 8);
                stall_odds = $urandom_range(1, 8);
            end
            run_phase(PHASE_ITEMS);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && results_owed == 0)
            $display("[three_channel_moving_average_scaler] OK");
        else
            $display("[three_channel_moving_average_scaler] ERROR");
        $finish;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[three_channel_moving_average_scaler] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
